[rtl/hazard_pointer_reclaim_table_defines.svh]
// assertion macros for the hazard pointer reclaim table
// included by modules that carry concurrent checks
`ifndef HAZARD_POINTER_RECLAIM_TABLE_DEFINES_SVH
`define HAZARD_POINTER_RECLAIM_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HPR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HPR_ASSERT_IMP(label, clk, rst, ante, cons)
`define HPR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/hpr_pkg.sv]
// shared types and constants for the hazard pointer reclaim table
// no dependencies
package hpr_pkg;
   localparam int SLOTS_PER_THREAD_DEF = 2;
   localparam int MAX_THREADS_DEF      = 8;
   localparam int RETIRE_LIMIT_DEF     = 32;
   localparam int ADDRESS_BITS_DEF     = 48;

   localparam int KIND_W  = 3;
   localparam int THR_W   = 3;
   localparam int SLOT_W  = 1;
   localparam int PTR_W   = 48;
   localparam int TAG_W   = 4;
   localparam int RK_W    = 2;
   localparam int REM_W   = 6;

   typedef enum logic [KIND_W-1:0] {
      KIND_REGISTER = 3'd0,
      KIND_ANNOUNCE = 3'd1,
      KIND_CLEAR    = 3'd2,
      KIND_CLEAR_ALL= 3'd3,
      KIND_RETIRE   = 3'd4,
      KIND_FLUSH    = 3'd5
   } kind_type;

   typedef enum logic [RK_W-1:0] {
      RK_DONE = 2'd0,
      RK_FREED = 2'd1,
      RK_FULL = 2'd2,
      RK_UNREG = 2'd3
   } result_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_CLR_ALL, ST_SCAN_RD, ST_SCAN_WAIT, ST_SCAN_CHK,
      ST_SCAN_EMIT, ST_SCAN_END, ST_RESP
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [THR_W-1:0]  thread;
      logic [SLOT_W-1:0] slot;
      logic [PTR_W-1:0]  pointer;
      logic [TAG_W-1:0]  deleter_tag;
   } req_type;

   typedef struct packed {
      logic [RK_W-1:0]  result_kind;
      logic [THR_W-1:0] thread_index;
      logic [PTR_W-1:0] freed_pointer;
      logic [TAG_W-1:0] freed_tag;
      logic [REM_W-1:0] remaining;
      logic             last;
   } rsp_type;
endpackage

[rtl/hpr_stream_if.sv]
// valid/ready channel carrying a packed payload
// the payload type comes from a parameter; no dependencies
interface hpr_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/hpr_ram.sv]
// generic single-port-write, one-read synchronous ram, registered read
// no dependencies
module hpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

[rtl/hpr_slots.sv]
// hazard slot table in flip-flops with a parallel match against one address
// depends on hpr_pkg
module hpr_slots #(
   parameter int SLOTS_PER_THREAD = hpr_pkg::SLOTS_PER_THREAD_DEF,
   parameter int MAX_THREADS      = hpr_pkg::MAX_THREADS_DEF,
   parameter int ADDRESS_BITS     = hpr_pkg::ADDRESS_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_THREADS*SLOTS_PER_THREAD+1)-1:0] wr_idx,
   input  logic [ADDRESS_BITS-1:0]           wr_data,
   input  logic [$clog2(MAX_THREADS*SLOTS_PER_THREAD+1)-1:0] active_n,
   input  logic [ADDRESS_BITS-1:0]           probe,
   output logic                              hit
);
   import hpr_pkg::*;
   localparam int NS = MAX_THREADS * SLOTS_PER_THREAD;
   localparam int IW = $clog2(NS + 1);

   logic [ADDRESS_BITS-1:0] slot_ff [NS];
   logic [NS-1:0]           match;

   // slot writes, cleared at reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (reset) begin
            slot_ff[i] <= '0;
         end else if (wr_en && wr_idx == IW'(i)) begin
            slot_ff[i] <= wr_data;
         end
      end
   end

   // match nonzero slots of registered threads
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         match[i] = (slot_ff[i] != '0) && (slot_ff[i] == probe) && (IW'(i) < active_n);
      end
   end
   assign hit = |match;
endmodule

[rtl/hazard_pointer_reclaim_table.sv]
// Hazard pointer reclaim table, top level.
// Channels: req (kind, thread, slot, pointer, deleter_tag) and rsp
// (result_kind, thread_index, freed_pointer, freed_tag, remaining, last).
// Hazard slots sit in flip-flops with a parallel compare; each thread's
// retire list sits in synchronous rams (addresses and tags) of
// MAX_THREADS*RETIRE_LIMIT entries with a registered read.
// Register, announce, clear, out-of-range and unknown items, and retire
// without scan, pass through decode and response to the single result.
// A scan walks the list one entry at a time, set by the single ram read
// port, through read, wait and check; a survivor is compacted in place
// with the ram write port, and a freed entry also passes the emit state
// to issue its beat; it ends with one done beat giving the remaining count.
// One item is in flight at a time.
// Reset (synchronous, active high) clears slots, registration and retire
// counts; list contents stay undefined and are never read past the count.
// When rsp is stalled the beat holds in the output register and the
// sequencer waits; req is not taken until the item's last beat leaves.
`include "hazard_pointer_reclaim_table_defines.svh"
module hazard_pointer_reclaim_table #(
   parameter int SLOTS_PER_THREAD = hpr_pkg::SLOTS_PER_THREAD_DEF,
   parameter int MAX_THREADS      = hpr_pkg::MAX_THREADS_DEF,
   parameter int RETIRE_LIMIT     = hpr_pkg::RETIRE_LIMIT_DEF,
   parameter int ADDRESS_BITS     = hpr_pkg::ADDRESS_BITS_DEF
) (
   input logic clock,
   input logic reset,
   hpr_stream_if.sink   req,
   hpr_stream_if.source rsp
);
   import hpr_pkg::*;
   localparam int NS    = MAX_THREADS * SLOTS_PER_THREAD;
   localparam int SIW   = $clog2(NS + 1);
   localparam int SLW   = (SLOTS_PER_THREAD > 1) ? $clog2(SLOTS_PER_THREAD) : 1;
   localparam int CW    = $clog2(RETIRE_LIMIT + 1);
   localparam int RW    = $clog2(MAX_THREADS + 1);
   localparam int DEPTH = MAX_THREADS * RETIRE_LIMIT;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;
   req_type   cur_ff;
   logic [RW-1:0] reg_cnt_ff, reg_cnt_in;
   logic [CW-1:0] cnt_ff [MAX_THREADS];
   logic [CW-1:0] idx_ff, idx_in, keep_ff, keep_in, cnt_cur;
   logic [SLW:0]  clr_ff, clr_in;
   rsp_type       out_ff, out_in;
   logic          out_v_ff, out_v_in;
   logic          cnt_we;
   logic [CW-1:0] cnt_wd;
   logic [ADDRESS_BITS-1:0] ptr_cur, rd_addr_d;
   logic [TAG_W-1:0] rd_tag_d;
   logic [AW-1:0] base, ram_rd, ram_wr;
   logic          ram_we, slot_we, hit, thr_ok;
   logic [SIW-1:0] slot_idx;
   logic [ADDRESS_BITS-1:0] slot_wd;

   assign ptr_cur  = cur_ff.pointer[ADDRESS_BITS-1:0];
   assign thr_ok   = {1'b0, cur_ff.thread} < (RW+1)'(reg_cnt_ff) &&
                     32'(cur_ff.thread) < MAX_THREADS;
   assign cnt_cur  = cnt_ff[cur_ff.thread[$clog2(MAX_THREADS > 1 ? MAX_THREADS : 2)-1:0]];
   assign base     = AW'(32'(cur_ff.thread) * RETIRE_LIMIT);
   assign ram_rd   = base + AW'(idx_ff);

   hpr_ram #(.WIDTH(ADDRESS_BITS), .DEPTH(DEPTH)) u_addr (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wr),
      .wr_data(state_ff == ST_DECODE ? ptr_cur : rd_addr_d),
      .rd_addr(ram_rd), .rd_data(rd_addr_d));
   hpr_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_tag (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wr),
      .wr_data(state_ff == ST_DECODE ? cur_ff.deleter_tag : rd_tag_d),
      .rd_addr(ram_rd), .rd_data(rd_tag_d));

   hpr_slots #(.SLOTS_PER_THREAD(SLOTS_PER_THREAD), .MAX_THREADS(MAX_THREADS),
      .ADDRESS_BITS(ADDRESS_BITS)) u_slots (
      .clock(clock), .reset(reset), .wr_en(slot_we), .wr_idx(slot_idx),
      .wr_data(slot_wd),
      .active_n(SIW'(32'(reg_cnt_ff) * SLOTS_PER_THREAD)),
      .probe(rd_addr_d), .hit(hit));

   assign req.ready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.payload = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req.valid && req.ready) state_in = ST_DECODE;
         ST_DECODE: begin
            if (cur_ff.kind == KIND_REGISTER || cur_ff.kind > KIND_FLUSH || !thr_ok)
               state_in = ST_RESP;
            else if (cur_ff.kind == KIND_CLEAR_ALL) state_in = ST_CLR_ALL;
            else if (cur_ff.kind == KIND_FLUSH) state_in = ST_SCAN_RD;
            else if (cur_ff.kind == KIND_RETIRE && 32'(cnt_cur) + 1 >= RETIRE_LIMIT)
               state_in = ST_SCAN_RD;
            else state_in = ST_RESP;
         end
         ST_CLR_ALL:   if (32'(clr_ff) + 1 >= SLOTS_PER_THREAD) state_in = ST_RESP;
         ST_SCAN_RD:   state_in = (idx_ff < cnt_cur) ? ST_SCAN_WAIT : ST_SCAN_END;
         ST_SCAN_WAIT: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK:  state_in = hit ? ST_SCAN_RD : ST_SCAN_EMIT;
         ST_SCAN_EMIT: if (!out_v_ff) state_in = ST_SCAN_RD;
         ST_SCAN_END:  if (!out_v_ff) state_in = ST_IDLE;
         ST_RESP:      if (!out_v_ff) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs per state
   always_comb begin
      reg_cnt_in = reg_cnt_ff;
      idx_in = idx_ff;
      keep_in = keep_ff;
      clr_in = clr_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && !rsp.ready;
      cnt_we = 1'b0;
      cnt_wd = '0;
      ram_we = 1'b0;
      ram_wr = base + AW'(keep_ff);
      slot_we = 1'b0;
      slot_idx = SIW'(32'(cur_ff.thread) * SLOTS_PER_THREAD + 32'(cur_ff.slot));
      slot_wd = '0;
      unique case (state_ff)
         ST_DECODE: begin
            idx_in = '0;
            keep_in = '0;
            clr_in = '0;
            // retire appends if room, before any scan
            if (cur_ff.kind == KIND_RETIRE && thr_ok && 32'(cnt_cur) < RETIRE_LIMIT) begin
               ram_we = 1'b1;
               ram_wr = base + AW'(cnt_cur);
               cnt_we = 1'b1;
               cnt_wd = cnt_cur + 1'b1;
            end
         end
         ST_CLR_ALL: begin
            slot_we = 1'b1;
            slot_idx = SIW'(32'(cur_ff.thread) * SLOTS_PER_THREAD + 32'(clr_ff));
            clr_in = clr_ff + 1'b1;
         end
         ST_SCAN_CHK: begin
            if (hit) begin
               // compact the survivor in place
               idx_in = idx_ff + 1'b1;
               ram_we = 1'b1;
               keep_in = keep_ff + 1'b1;
            end
         end
         // read address holds on the freed entry until its beat is issued
         ST_SCAN_EMIT: if (!out_v_ff) begin
            idx_in = idx_ff + 1'b1;
            out_v_in = 1'b1;
            out_in = '0;
            out_in.result_kind = RK_FREED;
            out_in.freed_pointer = PTR_W'(rd_addr_d);
            out_in.freed_tag = rd_tag_d;
         end
         ST_SCAN_END: if (!out_v_ff) begin
            cnt_we = 1'b1;
            cnt_wd = keep_ff;
            out_v_in = 1'b1;
            out_in = '0;
            out_in.remaining = REM_W'(keep_ff);
            out_in.last = 1'b1;
         end
         ST_RESP: if (!out_v_ff) begin
            out_v_in = 1'b1;
            out_in = '0;
            out_in.last = 1'b1;
            if (cur_ff.kind == KIND_REGISTER) begin
               if (32'(reg_cnt_ff) >= MAX_THREADS) begin
                  out_in.result_kind = RK_FULL;
               end else begin
                  out_in.thread_index = THR_W'(reg_cnt_ff);
                  reg_cnt_in = reg_cnt_ff + 1'b1;
               end
            end else if (cur_ff.kind <= KIND_FLUSH) begin
               if (!thr_ok) begin
                  out_in.result_kind = RK_UNREG;
               end else begin
                  out_in.remaining = REM_W'(cnt_cur);
                  if ((cur_ff.kind == KIND_ANNOUNCE || cur_ff.kind == KIND_CLEAR) &&
                      32'(cur_ff.slot) < SLOTS_PER_THREAD) begin
                     slot_we = 1'b1;
                     slot_wd = (cur_ff.kind == KIND_ANNOUNCE) ? ptr_cur : '0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         reg_cnt_ff <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < MAX_THREADS; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         reg_cnt_ff <= reg_cnt_in;
         out_v_ff <= out_v_in;
         if (cnt_we) cnt_ff[cur_ff.thread[$clog2(MAX_THREADS > 1 ? MAX_THREADS : 2)-1:0]] <= cnt_wd;
         if (state_ff == ST_RESP && !out_v_ff && cur_ff.kind == KIND_REGISTER &&
             32'(reg_cnt_ff) < MAX_THREADS)
            cnt_ff[reg_cnt_ff[$clog2(MAX_THREADS > 1 ? MAX_THREADS : 2)-1:0]] <= '0;
      end
      if (req.valid && req.ready) cur_ff <= req.payload;
      idx_ff <= idx_in;
      keep_ff <= keep_in;
      clr_ff <= clr_in;
      out_ff <= out_in;
   end

   `HPR_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, 32'(reg_cnt_ff) <= MAX_THREADS)
   `HPR_ASSERT_IMP(a_keep_le_idx, clock, reset, state_ff == ST_SCAN_RD, keep_ff <= idx_ff)
   `HPR_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req.ready)
   `HPR_ASSERT_NXT(a_freed_kind, clock, reset,
      state_ff == ST_SCAN_EMIT && !out_v_ff, out_ff.result_kind == RK_FREED && !out_ff.last)
endmodule

[sim/hazard_pointer_reclaim_table_checker.sv]
// checker for the hazard pointer reclaim table: predicts every rsp beat
// from accepted req beats and compares them; depends on hpr_pkg
`timescale 1ns / 100ps
module hazard_pointer_reclaim_table_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  hpr_pkg::req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  hpr_pkg::rsp_type rsp_payload,
   output int   fail_count,
   output int   pending_count,
   output int   freed_count,
   output int   scan_count
);
   import hpr_pkg::*;

   localparam int SLOTS = SLOTS_PER_THREAD_DEF;
   localparam int THREADS = MAX_THREADS_DEF;
   localparam int LIMIT = RETIRE_LIMIT_DEF;

   logic [PTR_W-1:0] hazard_tab [THREADS*SLOTS];
   logic [PTR_W-1:0] list_addr [THREADS][LIMIT];
   logic [TAG_W-1:0] list_tag [THREADS][LIMIT];
   int               list_len [THREADS];
   int               thread_total;
   rsp_type          expected_beats [$];

   function automatic rsp_type make_beat(result_kind_type rk, int ti, logic [PTR_W-1:0] fp,
                                          logic [TAG_W-1:0] ft, int rem, logic lst);
      rsp_type b;
      b.result_kind   = rk;
      b.thread_index  = THR_W'(ti);
      b.freed_pointer = fp;
      b.freed_tag     = ft;
      b.remaining     = REM_W'(rem);
      b.last          = lst;
      return b;
   endfunction

   function automatic bit guarded(logic [PTR_W-1:0] a);
      for (int i = 0; i < thread_total * SLOTS; i++)
         if (hazard_tab[i] != 0 && hazard_tab[i] == a) return 1;
      return 0;
   endfunction

   // walk the list, free unguarded nodes, compact survivors
   task automatic reclaim_scan(int t);
      int keep;
      keep = 0;
      scan_count++;
      for (int i = 0; i < list_len[t]; i++) begin
         if (guarded(list_addr[t][i])) begin
            list_addr[t][keep] = list_addr[t][i];
            list_tag[t][keep] = list_tag[t][i];
            keep++;
         end else begin
            expected_beats.push_back(make_beat(RK_FREED, 0, list_addr[t][i],
                                               list_tag[t][i], 0, 1'b0));
            freed_count++;
         end
      end
      list_len[t] = keep;
      expected_beats.push_back(make_beat(RK_DONE, 0, '0, '0, keep, 1'b1));
   endtask

   task automatic predict_item(req_type r);
      int t;
      t = r.thread;
      if (r.kind == KIND_REGISTER) begin
         if (thread_total >= THREADS)
            expected_beats.push_back(make_beat(RK_FULL, 0, '0, '0, 0, 1'b1));
         else begin
            list_len[thread_total] = 0;
            expected_beats.push_back(make_beat(RK_DONE, thread_total, '0, '0, 0, 1'b1));
            thread_total++;
         end
      end else if (r.kind > KIND_FLUSH) begin
         expected_beats.push_back(make_beat(RK_DONE, 0, '0, '0, 0, 1'b1));
      end else if (t >= thread_total) begin
         expected_beats.push_back(make_beat(RK_UNREG, 0, '0, '0, 0, 1'b1));
      end else begin
         case (kind_type'(r.kind))
            KIND_ANNOUNCE: hazard_tab[t*SLOTS + r.slot] = r.pointer;
            KIND_CLEAR:    hazard_tab[t*SLOTS + r.slot] = '0;
            KIND_CLEAR_ALL: for (int i = 0; i < SLOTS; i++) hazard_tab[t*SLOTS + i] = '0;
            KIND_RETIRE: begin
               if (list_len[t] < LIMIT) begin
                  list_addr[t][list_len[t]] = r.pointer;
                  list_tag[t][list_len[t]] = r.deleter_tag;
                  list_len[t]++;
               end
            end
            default: ;
         endcase
         if (r.kind == KIND_FLUSH || (r.kind == KIND_RETIRE && list_len[t] >= LIMIT))
            reclaim_scan(t);
         else
            expected_beats.push_back(make_beat(RK_DONE, 0, '0, '0, list_len[t], 1'b1));
      end
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < THREADS*SLOTS; i++) hazard_tab[i] = '0;
         for (int i = 0; i < THREADS; i++) list_len[i] = 0;
         thread_total = 0;
         expected_beats.delete();
         fail_count = 0;
         freed_count = 0;
         scan_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected rsp beat %p", rsp_payload);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_payload.result_kind !== want.result_kind) begin
                  $error("result_kind exp %0d got %0d", want.result_kind,
                         rsp_payload.result_kind);
                  fail_count++;
               end
               if (rsp_payload.thread_index !== want.thread_index) begin
                  $error("thread_index exp %0d got %0d", want.thread_index,
                         rsp_payload.thread_index);
                  fail_count++;
               end
               if (rsp_payload.freed_pointer !== want.freed_pointer) begin
                  $error("freed_pointer exp %h got %h", want.freed_pointer,
                         rsp_payload.freed_pointer);
                  fail_count++;
               end
               if (rsp_payload.freed_tag !== want.freed_tag) begin
                  $error("freed_tag exp %0d got %0d", want.freed_tag, rsp_payload.freed_tag);
                  fail_count++;
               end
               if (rsp_payload.remaining !== want.remaining) begin
                  $error("remaining exp %0d got %0d", want.remaining, rsp_payload.remaining);
                  fail_count++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last exp %0d got %0d", want.last, rsp_payload.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_item(req_payload);
      end
      pending_count = expected_beats.size();
   end
endmodule

[sim/hazard_pointer_reclaim_table_tb.sv]
// stimulus and verdict for the hazard pointer reclaim table
// depends on hpr_pkg, hpr_stream_if, the block and its checker
`timescale 1ns / 100ps
module hazard_pointer_reclaim_table_tb;
   import hpr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   int      fail_count, pending_count, freed_count, scan_count;
   int      cycle_count;
   int      send_idle_pct, stall_pct;
   int      items_sent;
   logic [PTR_W-1:0] pool [8];

   hpr_stream_if #(.payload_type(req_type)) req (.clock(clock));
   hpr_stream_if #(.payload_type(rsp_type)) rsp (.clock(clock));

   hazard_pointer_reclaim_table uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   hazard_pointer_reclaim_table_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload),
      .fail_count(fail_count), .pending_count(pending_count),
      .freed_count(freed_count), .scan_count(scan_count));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // send one beat, with optional idle cycles ahead of it
   task automatic send_item(logic [2:0] kind, logic [2:0] thr, logic slot,
                            logic [PTR_W-1:0] ptr, logic [TAG_W-1:0] tag);
      req_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      r.kind = kind;
      r.thread = thr;
      r.slot = slot;
      r.pointer = ptr;
      r.deleter_tag = tag;
      req.valid <= 1'b1;
      req.payload <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
   endtask

   // mostly pooled pointers so hazards match retires
   function automatic logic [PTR_W-1:0] pick_pointer();
      if ($urandom_range(9) < 7) return pool[$urandom_range(7)];
      return PTR_W'({$urandom(), $urandom()});
   endfunction

   task automatic random_item();
      int sel;
      sel = $urandom_range(99);
      if (sel < 3)
         send_item(KIND_REGISTER, 3'($urandom), 1'($urandom),
                   PTR_W'({$urandom(), $urandom()}), TAG_W'($urandom));
      else if (sel < 20)
         send_item(KIND_ANNOUNCE, 3'($urandom), 1'($urandom), pick_pointer(),
                   TAG_W'($urandom));
      else if (sel < 28)
         send_item(KIND_CLEAR, 3'($urandom), 1'($urandom), pick_pointer(), TAG_W'($urandom));
      else if (sel < 32)
         send_item(KIND_CLEAR_ALL, 3'($urandom), 1'($urandom), pick_pointer(),
                   TAG_W'($urandom));
      else if (sel < 88)
         send_item(KIND_RETIRE, 3'($urandom_range(3)), 1'($urandom), pick_pointer(),
                   TAG_W'($urandom));
      else if (sel < 96)
         send_item(KIND_FLUSH, 3'($urandom), 1'($urandom), pick_pointer(), TAG_W'($urandom));
      else
         send_item(3'($urandom_range(7, 6)), 3'($urandom), 1'($urandom),
                   PTR_W'({$urandom(), $urandom()}), TAG_W'($urandom));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      cycle_count = 0;
      items_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.payload <= '0;
      for (int i = 0; i < 8; i++) pool[i] = PTR_W'({$urandom(), $urandom()});
      pool[0] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: unregistered use, registration, slot and scan corners
      send_item(KIND_ANNOUNCE, 3'd0, 1'b0, 48'h1, 4'h0);
      send_item(3'd6, 3'd7, 1'b1, '1, 4'hf);
      send_item(3'd7, 3'd0, 1'b0, '0, 4'h0);
      send_item(KIND_REGISTER, 3'd5, 1'b1, '1, 4'hf);
      send_item(KIND_REGISTER, 3'd0, 1'b0, '0, 4'h0);
      send_item(KIND_ANNOUNCE, 3'd0, 1'b0, '1, 4'h0);
      send_item(KIND_ANNOUNCE, 3'd1, 1'b1, pool[1], 4'h0);
      send_item(KIND_RETIRE, 3'd0, 1'b0, '1, 4'hf);
      send_item(KIND_RETIRE, 3'd0, 1'b1, '0, 4'h0);
      send_item(KIND_RETIRE, 3'd0, 1'b0, pool[1], 4'h5);
      send_item(KIND_FLUSH, 3'd0, 1'b0, '0, 4'h0);
      send_item(KIND_CLEAR, 3'd0, 1'b0, '0, 4'h0);
      send_item(KIND_CLEAR_ALL, 3'd1, 1'b0, '0, 4'h0);
      send_item(KIND_FLUSH, 3'd0, 1'b1, '1, 4'hf);
      send_item(KIND_RETIRE, 3'd2, 1'b0, 48'h5, 4'h1);
      // fill thread 1's list with a guarded node to hit the full-list retire
      send_item(KIND_ANNOUNCE, 3'd1, 1'b0, pool[2], 4'h0);
      repeat (33) send_item(KIND_RETIRE, 3'd1, 1'b0, pool[2], 4'ha);
      send_item(KIND_CLEAR_ALL, 3'd1, 1'b1, '0, 4'h0);
      for (int i = 0; i < 7; i++) send_item(KIND_REGISTER, 3'd0, 1'b0, '0, 4'h0);
      send_item(KIND_FLUSH, 3'd1, 1'b0, '0, 4'h0);
      // pause until everything has come back
      drain();

      // random phases with varying idle and stall
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 38 : 45) : 0;
         stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 38 : 45) : 0;
         repeat (55) random_item();
      end
      send_idle_pct = 0;
      stall_pct = 0;

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d items, %0d scans, %0d nodes freed", items_sent, scan_count,
               freed_count);
      $display("registration overflow, unregistered threads, full lists and idle phases");
      if (fail_count == 0 && pending_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/hpr_pkg.sv
rtl/hpr_stream_if.sv
rtl/hpr_ram.sv
rtl/hpr_slots.sv
rtl/hazard_pointer_reclaim_table.sv
sim/hazard_pointer_reclaim_table_checker.sv
sim/hazard_pointer_reclaim_table_tb.sv
